@@ src/frgf_pkg.sv @@
// ----------------------------------------------------------------------------
// frgf_pkg
// Shared types, font modes and address constants for the serial font ROM
// glyph fetch block.
// ----------------------------------------------------------------------------
package frgf_pkg;

   // font modes
   localparam logic [2:0] MODE_GB16  = 3'd0;
   localparam logic [2:0] MODE_GB12  = 3'd1;
   localparam logic [2:0] MODE_ASC16 = 3'd2;
   localparam logic [2:0] MODE_ASC12 = 3'd3;
   localparam logic [2:0] MODE_ASC7  = 3'd4;
   localparam logic [2:0] MODE_G2U   = 3'd5;

   localparam logic [31:0] CMD_READ   = 32'h0300_0000;
   localparam logic [23:0] GB16_BASE  = 24'h00_0000;
   localparam logic [23:0] GB12_BASE  = 24'h03_CF80;
   localparam logic [23:0] ASC16_BASE = 24'h03_B7C0;
   localparam logic [23:0] ASC12_BASE = 24'h06_6D40;
   localparam logic [23:0] ASC7_BASE  = 24'h03_BFC0;
   localparam logic [23:0] G2U_BASE   = 24'h00_2F00;

   localparam int ZONE_ROW    = 94;
   localparam int GB16_HANZI  = 846;
   localparam int GB12_HANZI  = 376;
   localparam int GB12_A9_OFS = 282;
   localparam int G2U_HANZI   = 368;
   localparam logic [7:0] ZONE_FIRST = 8'hA1;

   localparam logic [5:0] CNT_GB16  = 6'd32;
   localparam logic [5:0] CNT_GB12  = 6'd24;
   localparam logic [5:0] CNT_ASC16 = 6'd16;
   localparam logic [5:0] CNT_ASC12 = 6'd12;
   localparam logic [5:0] CNT_ASC7  = 6'd8;
   localparam logic [5:0] CNT_G2U   = 6'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // one decoded item as it waits between front and back
   typedef struct packed {
      logic        is_tick;
      logic        miso;
      logic        bad;
      logic        fallback;
      logic [5:0]  count;
      logic [23:0] where;
      logic [23:0] second_where;
   } queue_entry_type;

   function automatic logic is_printable(input logic [7:0] c);
      return (c >= 8'h20) && (c <= 8'h7E);
   endfunction

   function automatic logic [23:0] ascii16_location(input logic [7:0] c);
      logic [7:0] ofs;
      ofs = c - 8'h20;
      return ({16'h0, ofs} << 4) + ASC16_BASE;
   endfunction

endpackage

@@ src/frgf_front.sv @@
// ----------------------------------------------------------------------------
// frgf_front
// Classifies an incoming item and, for a glyph request, works out the
// font ROM address, byte count, ascii fallback and refusal.
// ----------------------------------------------------------------------------
module frgf_front import frgf_pkg::*; (
   input  logic            kind,
   input  logic [2:0]      font_mode,
   input  logic [15:0]     char_code,
   input  logic            miso_bit,
   output queue_entry_type entry
);

   logic [7:0]  hi;
   logic [7:0]  lo;
   logic [7:0]  hi_a;
   logic [7:0]  hi_b;
   logic [7:0]  col;
   logic        lo_ok;
   logic [6:0]  row_m;
   logic [9:0]  ofs;
   logic        idx_zero;
   logic        fallback;
   logic        bad;
   logic [5:0]  count;
   logic [13:0] gb_idx;
   logic [23:0] idx_w;
   logic [23:0] asc_ofs;
   logic [23:0] where;

   assign hi    = char_code[15:8];
   assign lo    = char_code[7:0];
   assign hi_a  = hi - ZONE_FIRST;
   assign hi_b  = hi - 8'hB0;
   assign col   = lo - ZONE_FIRST;
   assign lo_ok = lo >= ZONE_FIRST;

   always_comb begin
      row_m    = '0;
      ofs      = '0;
      idx_zero = 1'b0;
      fallback = 1'b0;
      bad      = 1'b0;
      count    = '0;
      unique case (font_mode)
         MODE_GB16: begin
            count = CNT_GB16;
            if (hi >= 8'hA4 && hi <= 8'hA8 && lo_ok) begin
               idx_zero = 1'b1;
            end else if (hi >= 8'hA1 && hi <= 8'hA9 && lo_ok) begin
               row_m = hi_a[6:0];
            end else if (hi >= 8'hB0 && hi <= 8'hF7 && lo_ok) begin
               row_m = hi_b[6:0];
               ofs   = 10'(GB16_HANZI);
            end else begin
               fallback = 1'b1;
            end
         end
         MODE_GB12: begin
            count = CNT_GB12;
            if (hi >= 8'hA1 && hi <= 8'hA3 && lo_ok) begin
               row_m = hi_a[6:0];
            end else if (hi == 8'hA9 && lo_ok) begin
               ofs = 10'(GB12_A9_OFS);
            end else if (hi >= 8'hB0 && hi <= 8'hF7 && lo_ok) begin
               row_m = hi_b[6:0];
               ofs   = 10'(GB12_HANZI);
            end else begin
               fallback = 1'b1;
            end
         end
         MODE_ASC16: begin
            count = CNT_ASC16;
            bad   = !is_printable(lo);
         end
         MODE_ASC12: begin
            count = CNT_ASC12;
            bad   = !is_printable(lo);
         end
         MODE_ASC7: begin
            count = CNT_ASC7;
            bad   = !is_printable(lo);
         end
         MODE_G2U: begin
            count = CNT_G2U;
            if (hi >= 8'hA1 && hi <= 8'hA3 && lo_ok) begin
               row_m = hi_a[6:0];
            end else if (hi == 8'hA9 && lo_ok && lo <= 8'hF6) begin
               ofs = 10'(GB12_A9_OFS);
            end else if (hi >= 8'hB0 && hi <= 8'hF7 && lo_ok) begin
               row_m = hi_b[6:0];
               ofs   = 10'(G2U_HANZI);
            end else begin
               idx_zero = 1'b1;
            end
         end
         default: begin
            bad = 1'b1;
         end
      endcase
      // out-of-zone gb code is served as two ascii 8x16 glyphs
      if (fallback) begin
         count = CNT_ASC16;
         bad   = !is_printable(hi) || !is_printable(lo);
      end
   end

   assign gb_idx  = 14'(row_m) * 14'(ZONE_ROW) + 14'(col) + 14'(ofs);
   assign idx_w   = idx_zero ? '0 : 24'(gb_idx);
   assign asc_ofs = 24'(lo - 8'h20);

   always_comb begin
      where = '0;
      if (fallback) begin
         where = ascii16_location(hi);
      end else begin
         unique case (font_mode)
            MODE_GB16:  where = (idx_w << 5) + GB16_BASE;
            MODE_GB12:  where = (idx_w << 4) + (idx_w << 3) + GB12_BASE;
            MODE_ASC16: where = ascii16_location(lo);
            MODE_ASC12: where = (asc_ofs << 3) + (asc_ofs << 2) + ASC12_BASE;
            MODE_ASC7:  where = (asc_ofs << 3) + ASC7_BASE;
            MODE_G2U:   where = (idx_w << 1) + G2U_BASE;
            default:    where = '0;
         endcase
      end
   end

   assign entry.is_tick      = kind;
   assign entry.miso         = miso_bit;
   assign entry.bad          = bad;
   assign entry.fallback     = fallback;
   assign entry.count        = count;
   assign entry.where        = where;
   assign entry.second_where = ascii16_location(lo);

endmodule

@@ src/frgf_queue.sv @@
// ----------------------------------------------------------------------------
// frgf_queue
// Small first-in first-out buffer of decoded items between front and back.
// ----------------------------------------------------------------------------
module frgf_queue import frgf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head_entry,
   output logic            not_empty,
   output logic            full
);

   queue_entry_type       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     fill_ff, fill_in;

   function automatic logic [QUEUE_AW-1:0] bump(input logic [QUEUE_AW-1:0] p);
      return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign not_empty  = fill_ff != '0;
   assign full       = fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/frgf_back.sv @@
// ----------------------------------------------------------------------------
// frgf_back
// SPI read engine: starts reads on requests, shifts command and address out
// and data bytes in on ticks, and holds each response in an output register.
// ----------------------------------------------------------------------------
module frgf_back import frgf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  queue_entry_type entry,
   input  logic            entry_valid,
   output logic            pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [15:0]     rsp_tdata,
   output logic            rsp_tlast
);

   logic        busy_ff, busy_in;
   logic        in_data_ff, in_data_in;
   logic [31:0] cmd_ff, cmd_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [5:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  asm_ff, asm_in;
   logic        second_pending_ff, second_pending_in;
   logic [23:0] second_addr_ff, second_addr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic        start;
   logic [23:0] start_where;
   logic [5:0]  start_count;
   logic        sel, mosi, valid, last, rej;
   logic [7:0]  value;
   logic [7:0]  asm_next;
   logic [5:0]  bytes_dec;

   assign pop      = entry_valid && (!rsp_valid_ff || rsp_tready);
   assign asm_next = {asm_ff[6:0], entry.miso};
   assign bytes_dec = bytes_left_ff - 1'b1;

   always_comb begin
      busy_in           = busy_ff;
      in_data_in        = in_data_ff;
      cmd_in            = cmd_ff;
      bit_count_in      = bit_count_ff;
      bytes_left_in     = bytes_left_ff;
      asm_in            = asm_ff;
      second_pending_in = second_pending_ff;
      second_addr_in    = second_addr_ff;
      start             = 1'b0;
      start_where       = entry.where;
      start_count       = entry.count;
      sel   = 1'b0;
      mosi  = 1'b0;
      valid = 1'b0;
      value = '0;
      last  = 1'b0;
      rej   = 1'b0;

      if (!entry.is_tick) begin
         rej = busy_ff || entry.bad;
         if (!rej) begin
            start             = 1'b1;
            second_pending_in = entry.fallback;
            if (entry.fallback) begin
               second_addr_in = entry.second_where;
            end
         end
      end else if (busy_ff) begin
         if (!in_data_ff && bytes_left_ff == '0) begin
            // gap between the two fallback reads, select released
            second_pending_in = 1'b0;
            start             = 1'b1;
            start_where       = second_addr_ff;
            start_count       = CNT_ASC16;
         end else if (!in_data_ff) begin
            sel    = 1'b1;
            mosi   = cmd_ff[31];
            cmd_in = {cmd_ff[30:0], 1'b0};
            if (bit_count_ff == 5'd31) begin
               bit_count_in = '0;
               in_data_in   = 1'b1;
               asm_in       = '0;
            end else begin
               bit_count_in = bit_count_ff + 1'b1;
            end
         end else begin
            sel    = 1'b1;
            asm_in = asm_next;
            if (bit_count_ff >= 5'd7) begin
               bit_count_in  = '0;
               valid         = 1'b1;
               value         = asm_next;
               asm_in        = '0;
               bytes_left_in = bytes_dec;
               if (bytes_dec == '0) begin
                  in_data_in = 1'b0;
                  if (!second_pending_ff) begin
                     busy_in = 1'b0;
                     last    = 1'b1;
                  end
               end
            end else begin
               bit_count_in = bit_count_ff + 1'b1;
            end
         end
      end

      if (start) begin
         cmd_in        = CMD_READ | {8'h00, start_where};
         bytes_left_in = start_count;
         bit_count_in  = '0;
         in_data_in    = 1'b0;
         asm_in        = '0;
         busy_in       = 1'b1;
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff           <= 1'b0;
         in_data_ff        <= 1'b0;
         cmd_ff            <= '0;
         bit_count_ff      <= '0;
         bytes_left_ff     <= '0;
         asm_ff            <= '0;
         second_pending_ff <= 1'b0;
         second_addr_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            busy_ff           <= busy_in;
            in_data_ff        <= in_data_in;
            cmd_ff            <= cmd_in;
            bit_count_ff      <= bit_count_in;
            bytes_left_ff     <= bytes_left_in;
            asm_ff            <= asm_in;
            second_pending_ff <= second_pending_in;
            second_addr_ff    <= second_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= {4'h0, rej, value, valid, mosi, sel};
         rsp_last_ff <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ src/font_rom_glyph_fetch.sv @@
// ----------------------------------------------------------------------------
// font_rom_glyph_fetch
// Serial font ROM glyph reader: address decode, item queue and SPI engine.
// ----------------------------------------------------------------------------
// Every accepted item, a glyph request or one serial clock tick, gives
// exactly one response, in order. The block takes one item per clock while
// the queue is not full: the address decode sits in front of a 4-entry
// queue, and the SPI engine drains the queue at one item per cycle, while
// the output register is free or being taken, into that register, from which
// each response is driven; the queue absorbs up to four items while the
// response side is held. A read costs 32 ticks of command and address plus
// 8 ticks per data byte; an out-of-zone gb code runs two 16-byte ascii reads
// with one idle tick between them.
module font_rom_glyph_fetch import frgf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // font_mode[2:0], char_code[18:3], miso_bit[19]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // select_active[0], mosi_bit[1], byte_valid[2],
                                    // byte_value[10:3], rejected[11]
   output logic        rsp_tlast    // last_byte
);

   queue_entry_type front_entry;
   queue_entry_type head_entry;
   logic            push;
   logic            pop;
   logic            not_empty;
   logic            full;

   assign req_tready = !full;
   assign push       = req_tvalid && req_tready;

   frgf_front u_front (
      .kind      (req_tuser),
      .font_mode (req_tdata[2:0]),
      .char_code (req_tdata[18:3]),
      .miso_bit  (req_tdata[19]),
      .entry     (front_entry)
   );

   frgf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .full       (full)
   );

   frgf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (head_entry),
      .entry_valid (not_empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ src/frgf_checker.sv @@
// ----------------------------------------------------------------------------
// frgf_checker
// Port-level checks on the glyph fetch responses, bound to the top level.
// ----------------------------------------------------------------------------
module frgf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // last marks a delivered byte only
   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2] && rsp_tdata[0])
      else $error("last without a byte");

   // a refusal carries no bus activity
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> !rsp_tdata[0] && !rsp_tdata[2] && !rsp_tlast)
      else $error("refusal with bus activity");

   // mosi only driven while selected, byte value zero unless valid
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[0]) &&
                     (rsp_tdata[2] || rsp_tdata[10:3] == 8'h00))
      else $error("field set outside its phase");

endmodule

bind font_rom_glyph_fetch frgf_checker u_frgf_checker (.*);
